/* design/lirsc_pkg.sv */
// ----------------------------------------------------------------------------
// lirsc_pkg
// Shared types, constants and helper functions of the linear-interpolation
// sample-rate converter.
// ----------------------------------------------------------------------------
package lirsc_pkg;

    // sizing
    localparam int FRAME_SLOTS  = 8;
    localparam int MAX_UPSAMPLE = 8;
    localparam int FRAC_BITS    = 16;

    localparam int SAMPLE_W = 32;
    localparam int CH_IDX_W = 3;
    localparam int CH_CNT_W = 4;
    localparam int RATIO_W  = 20;
    localparam int POS_W    = FRAC_BITS + 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = RATIO_W;

    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int FRAC_S_W = FRAC_BITS + 1;
    localparam int PROD_W   = DIFF_W + FRAC_S_W;

    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
    localparam int RATIO_MIN_I = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(RATIO_MIN_I);
    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(8 * (1 << FRAC_BITS));

    localparam logic [CH_CNT_W-1:0] CH_MAX = CH_CNT_W'(FRAME_SLOTS);
    localparam logic [CH_CNT_W-1:0] CH_MIN = CH_CNT_W'(1);

    localparam logic [RATIO_W-1:0]  STEP_RATIO_RST    = RATIO_W'(65536);
    localparam logic [CH_CNT_W-1:0] CHANNEL_COUNT_RST = CH_CNT_W'(2);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_RATIO    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = CFG_ADDR_W'(1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // payload words
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       restart;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [CH_IDX_W-1:0]        channel_index;
        logic                       last_of_run;
    } out_word_t;

    // what the back end has to do with a sample
    typedef enum logic [1:0] {
        KIND_STORE       = 2'd0,
        KIND_FIRST_FRAME = 2'd1,
        KIND_FRAME       = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_IDX_W-1:0]        slot;
        item_kind_t                 kind;
        logic                       restart;
    } queue_entry_t;

    // channel count held to 1..FRAME_SLOTS
    function automatic logic [CH_CNT_W-1:0] eff_channels(input logic [CH_CNT_W-1:0] n);
        logic [CH_CNT_W-1:0] r;
        r = n;
        if (r < CH_MIN)
            r = CH_MIN;
        if (r > CH_MAX)
            r = CH_MAX;
        return r;
    endfunction

    // step ratio held to the supported range
    function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] s);
        logic [RATIO_W-1:0] r;
        r = s;
        if (r < RATIO_MIN)
            r = RATIO_MIN;
        if (r > RATIO_MAX)
            r = RATIO_MAX;
        return r;
    endfunction

    // a + product, scaled down with truncation toward zero
    function automatic logic signed [SAMPLE_W-1:0] interp_finish(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [PROD_W-1:0]   prod
    );
        logic signed [PROD_W-1:0] num;
        logic signed [PROD_W-1:0] q;
        num = (PROD_W'(a) <<< FRAC_BITS) + prod;
        q   = num >>> FRAC_BITS;
        if (num[PROD_W-1] && (|num[FRAC_BITS-1:0]))
            q = q + PROD_W'(1);
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

/* design/linear_interp_sample_rate_converter_top.sv */
// ----------------------------------------------------------------------------
// linear_interp_sample_rate_converter_top
// Linear-interpolation resampler for interleaved 32-bit audio samples.
// ----------------------------------------------------------------------------
// Samples arrive one channel per word and are taken by the front end as long
// as the four-entry queue to the back end has room. The back end stores a
// sample that does not complete a frame straight from its idle state; a
// completing frame that emits nothing passes through the copy or check state
// and back to idle; and a frame that emits results goes through the check
// state and then, for each output word, a multiply step in the shared
// multiplier and an add and round into the output register. A stalled output
// holds the back end while the front keeps filling the queue. Configuration
// writes must happen while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_sample_rate_converter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  lirsc_pkg::in_word_t                   in_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output lirsc_pkg::out_word_t                  out_word,
    input  logic                                  cfg_wr,
    input  logic [lirsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lirsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [lirsc_pkg::RATIO_W-1:0]  step_ratio_reg;
    logic [lirsc_pkg::CH_CNT_W-1:0] channel_count_reg;
    logic [lirsc_pkg::CH_CNT_W-1:0] nch;
    logic [lirsc_pkg::RATIO_W-1:0]  ratio;

    lirsc_pkg::queue_entry_t push_entry, head;
    logic                    push, pop, empty, full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg    <= lirsc_pkg::STEP_RATIO_RST;
            channel_count_reg <= lirsc_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                lirsc_pkg::REG_STEP_RATIO:
                    step_ratio_reg <= cfg_data[lirsc_pkg::RATIO_W-1:0];
                lirsc_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[lirsc_pkg::CH_CNT_W-1:0];
                default:
                    step_ratio_reg <= step_ratio_reg;
            endcase
        end
    end

    // effective settings
    assign nch   = lirsc_pkg::eff_channels(channel_count_reg);
    assign ratio = lirsc_pkg::eff_ratio(step_ratio_reg);

    lirsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .nch      (nch),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    lirsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    lirsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (head),
        .q_empty   (empty),
        .q_pop     (pop),
        .nch       (nch),
        .ratio     (ratio),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

/* design/lirsc_front.sv */
// ----------------------------------------------------------------------------
// lirsc_front
// Accepts input words, tracks the channel position within the frame and
// tags each sample as plain store, first frame or frame completion.
// ----------------------------------------------------------------------------
module lirsc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  lirsc_pkg::in_word_t                   in_word,
    input  logic [lirsc_pkg::CH_CNT_W-1:0]        nch,
    input  logic                                  q_full,
    output logic                                  q_push,
    output lirsc_pkg::queue_entry_t               q_entry
);

    logic [lirsc_pkg::CH_IDX_W-1:0] ch_cnt_reg, ch_cnt_next;
    logic                           have_prev_reg, have_prev_next;
    logic [lirsc_pkg::CH_IDX_W-1:0] eff_cnt;
    logic                           eff_have;
    logic [lirsc_pkg::CH_CNT_W-1:0] cnt_plus;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // restart clears position in the frame before this word
    assign eff_cnt  = in_word.restart ? '0 : ch_cnt_reg;
    assign eff_have = in_word.restart ? 1'b0 : have_prev_reg;
    assign cnt_plus = {1'b0, eff_cnt} + lirsc_pkg::CH_CNT_W'(1);

    // classify the word
    always_comb
    begin
        q_entry.sample  = in_word.sample_in;
        q_entry.slot    = eff_cnt;
        q_entry.restart = in_word.restart;
        ch_cnt_next     = ch_cnt_reg;
        have_prev_next  = have_prev_reg;
        if (cnt_plus < nch)
        begin
            q_entry.kind = lirsc_pkg::KIND_STORE;
            if (q_push)
            begin
                ch_cnt_next    = cnt_plus[lirsc_pkg::CH_IDX_W-1:0];
                have_prev_next = eff_have;
            end
        end
        else
        begin
            q_entry.kind = eff_have ? lirsc_pkg::KIND_FRAME : lirsc_pkg::KIND_FIRST_FRAME;
            if (q_push)
            begin
                ch_cnt_next    = '0;
                have_prev_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            ch_cnt_reg    <= ch_cnt_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

/* design/lirsc_queue.sv */
// ----------------------------------------------------------------------------
// lirsc_queue
// Short first-in first-out queue of classified samples between the front
// and the back end.
// ----------------------------------------------------------------------------
module lirsc_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  lirsc_pkg::queue_entry_t       push_entry,
    input  logic                          pop,
    output lirsc_pkg::queue_entry_t       head,
    output logic                          empty,
    output logic                          full
);

    lirsc_pkg::queue_entry_t           mem [lirsc_pkg::QUEUE_DEPTH];
    logic [lirsc_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [lirsc_pkg::QCNT_W-1:0]      count_reg;
    logic                              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == lirsc_pkg::QCNT_W'(lirsc_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + lirsc_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + lirsc_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + lirsc_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - lirsc_pkg::QCNT_W'(1);
        end
    end

endmodule

/* design/lirsc_back.sv */
// ----------------------------------------------------------------------------
// lirsc_back
// Keeps the previous and current frames and the fractional position, and
// walks the interval between frames, one channel at a time through a multiply
// step and an emit step, into an output register.
// ----------------------------------------------------------------------------
module lirsc_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lirsc_pkg::queue_entry_t               q_head,
    input  logic                                  q_empty,
    output logic                                  q_pop,
    input  logic [lirsc_pkg::CH_CNT_W-1:0]        nch,
    input  logic [lirsc_pkg::RATIO_W-1:0]         ratio,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output lirsc_pkg::out_word_t                  out_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COPY  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                                   state_reg, state_next;
    logic signed [lirsc_pkg::SAMPLE_W-1:0]    prev_reg [lirsc_pkg::FRAME_SLOTS];
    logic signed [lirsc_pkg::SAMPLE_W-1:0]    cur_reg  [lirsc_pkg::FRAME_SLOTS];
    logic [lirsc_pkg::POS_W-1:0]              pos_reg, pos_next;
    logic [lirsc_pkg::CH_IDX_W-1:0]           ch_reg, ch_next;
    logic signed [lirsc_pkg::PROD_W-1:0]      prod_reg;
    logic signed [lirsc_pkg::SAMPLE_W-1:0]    a_reg;
    logic                                     last_reg;
    logic                                     out_valid_reg, out_valid_next;
    lirsc_pkg::out_word_t                     out_word_reg;

    logic                                     cur_wr;
    logic                                     copy_frame;
    logic                                     load_mul;
    logic                                     load_out;
    logic signed [lirsc_pkg::DIFF_W-1:0]      diff;
    logic signed [lirsc_pkg::FRAC_S_W-1:0]    frac_s;
    logic signed [lirsc_pkg::PROD_W-1:0]      prod_next;
    logic [lirsc_pkg::POS_W:0]                pos_step;
    logic                                     step_done;
    logic                                     ch_last;
    logic                                     out_free;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // shared datapath terms
    assign pos_step  = {1'b0, pos_reg} + {{(lirsc_pkg::POS_W - lirsc_pkg::RATIO_W + 1){1'b0}}, ratio};
    assign step_done = (pos_step >= {1'b0, lirsc_pkg::ONE_POS});
    assign ch_last   = (({1'b0, ch_reg} + lirsc_pkg::CH_CNT_W'(1)) >= nch);
    assign diff      = lirsc_pkg::DIFF_W'(cur_reg[ch_reg]) - lirsc_pkg::DIFF_W'(prev_reg[ch_reg]);
    assign frac_s    = {1'b0, pos_reg[lirsc_pkg::FRAC_BITS-1:0]};
    assign prod_next = diff * frac_s;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        q_pop          = 1'b0;
        cur_wr         = 1'b0;
        copy_frame     = 1'b0;
        load_mul       = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop  = 1'b1;
                    cur_wr = 1'b1;
                    if (q_head.restart)
                        pos_next = '0;
                    case (q_head.kind)
                        lirsc_pkg::KIND_FIRST_FRAME: state_next = ST_COPY;
                        lirsc_pkg::KIND_FRAME:       state_next = ST_CHECK;
                        default:                     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COPY:
            begin
                copy_frame = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (pos_reg >= lirsc_pkg::ONE_POS)
                begin
                    pos_next   = pos_reg - lirsc_pkg::ONE_POS;
                    copy_frame = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                load_mul   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    if (ch_last)
                    begin
                        ch_next = '0;
                        if (step_done)
                        begin
                            pos_next   = pos_step[lirsc_pkg::POS_W-1:0] - lirsc_pkg::ONE_POS;
                            copy_frame = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next   = pos_step[lirsc_pkg::POS_W-1:0];
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        ch_next    = ch_reg + lirsc_pkg::CH_IDX_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // frame storage
    always_ff @(posedge clk)
    begin
        if (cur_wr)
            cur_reg[q_head.slot] <= q_head.sample;
        if (copy_frame)
        begin
            for (int i = 0; i < lirsc_pkg::FRAME_SLOTS; i++)
                prev_reg[i] <= cur_reg[i];
        end
    end

    // multiply stage and output register payload
    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg <= prod_next;
            a_reg    <= prev_reg[ch_reg];
            last_reg <= ch_last && step_done;
        end
        if (load_out)
        begin
            out_word_reg.sample_out    <= lirsc_pkg::interp_finish(a_reg, prod_reg);
            out_word_reg.channel_index <= ch_reg;
            out_word_reg.last_of_run   <= last_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
